FILE: rtl/slt_pkg.sv
// Shared types, character codes and helpers for the shell line tokenizer.
package slt_pkg;

  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LESS   = 8'h3C;
  localparam logic [7:0] CH_GREATER = 8'h3E;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_PIPE   = 8'h7C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_EOL  = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_REPLAY,
    S_SPECIAL,
    S_SUMMARY
  } slt_state_t;

  // What follows once the buffered token has been replayed.
  typedef enum logic [1:0] {
    AFTER_NONE,
    AFTER_SPECIAL,
    AFTER_SUMMARY
  } slt_after_t;

  typedef struct packed {
    logic in_ready;
    logic capture;
    logic append;
    logic quote_set;
    logic quote_clr;
    logic clear_tok;
    logic rd_start;
    logic emit_tok;
    logic tok_last;
    logic emit_special;
    logic emit_summary;
    logic bump;
    logic line_clear;
  } slt_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic in_op;
    logic is_quote;
    logic is_space;
    logic is_special;
    logic quote_open;
    logic fill_zero;
    logic idx_last;
    logic out_free;
  } slt_status_t;

  function automatic logic is_special_char(input logic [7:0] c);
    return (c == CH_LPAREN) || (c == CH_RPAREN) || (c == CH_LESS) ||
           (c == CH_GREATER) || (c == CH_SEMI) || (c == CH_PIPE);
  endfunction

endpackage

FILE: rtl/slt_if.sv
// Valid/ready channel interfaces for line characters and token results.
interface slt_char_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] in_char;

  modport source (output valid, op, in_char, input ready);
  modport sink   (input valid, op, in_char, output ready);
endinterface

interface slt_token_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       token_end;
  logic       token_truncated;
  logic       line_done;
  logic [7:0] line_token_count;
  logic       last_of_run;

  modport source (output valid, out_char, token_end, token_truncated, line_done,
                  line_token_count, last_of_run, input ready);
  modport sink   (input valid, out_char, token_end, token_truncated, line_done,
                  line_token_count, last_of_run, output ready);
endinterface

FILE: rtl/slt_datapath.sv
// Tokenizer datapath: token buffer memory, counters, quote flag, output register.
module slt_datapath #(
  parameter int TOKEN_BUFFER_DEPTH = 32,
  parameter int COUNT_LIMIT        = 255
) (
  input  logic                clk,
  input  logic                rst,
  input  slt_pkg::slt_cmd_t   cmd,
  output slt_pkg::slt_status_t st,
  slt_char_if.sink            chars,
  slt_token_if.source         tokens
);
  import slt_pkg::*;

  localparam int IW = (TOKEN_BUFFER_DEPTH > 1) ? $clog2(TOKEN_BUFFER_DEPTH) : 1;
  localparam int FW = $clog2(TOKEN_BUFFER_DEPTH + 1);

  logic [7:0]    mem [TOKEN_BUFFER_DEPTH];
  logic [7:0]    rd_data;
  logic [FW-1:0] fill;
  logic          ovf;
  logic          quote_open;
  logic [7:0]    count;
  logic [IW-1:0] idx;
  logic [7:0]    held_char;

  logic          out_valid;
  logic [7:0]    out_char;
  logic          out_end;
  logic          out_trunc;
  logic          out_done;
  logic [7:0]    out_count;
  logic          out_last;

  logic [FW-1:0] idx_ext;
  logic          fill_full;
  logic          idx_last;
  logic          rd_next;
  logic          load;

  assign idx_ext   = FW'(idx);
  assign fill_full = (fill == FW'(TOKEN_BUFFER_DEPTH));
  assign idx_last  = ((idx_ext + FW'(1)) == fill);
  assign rd_next   = cmd.emit_tok && !idx_last;
  assign load      = cmd.emit_tok || cmd.emit_special || cmd.emit_summary;

  assign chars.ready = cmd.in_ready;

  always_comb begin
    st.in_valid   = chars.valid;
    st.in_op      = chars.op;
    st.is_quote   = (chars.in_char == CH_QUOTE);
    st.is_space   = (chars.in_char == CH_SPACE);
    st.is_special = is_special_char(chars.in_char);
    st.quote_open = quote_open;
    st.fill_zero  = (fill == '0);
    st.idx_last   = idx_last;
    st.out_free   = !out_valid || tokens.ready;
  end

  // token buffer: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.append && !fill_full) begin
      mem[fill[IW-1:0]] <= chars.in_char;
    end
    if (cmd.rd_start) begin
      rd_data <= mem[0];
    end else if (rd_next) begin
      rd_data <= mem[idx + IW'(1)];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      held_char <= chars.in_char;
    end
    if (cmd.rd_start) begin
      idx <= '0;
    end else if (rd_next) begin
      idx <= idx + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill       <= '0;
      ovf        <= 1'b0;
      quote_open <= 1'b0;
      count      <= '0;
    end else begin
      if (cmd.line_clear || cmd.clear_tok) begin
        fill <= '0;
        ovf  <= 1'b0;
      end else if (cmd.append) begin
        if (fill_full) begin
          ovf <= 1'b1;
        end else begin
          fill <= fill + FW'(1);
        end
      end
      if (cmd.line_clear || cmd.quote_clr) begin
        quote_open <= 1'b0;
      end else if (cmd.quote_set) begin
        quote_open <= 1'b1;
      end
      if (cmd.line_clear) begin
        count <= '0;
      end else if (cmd.bump && (count < 8'(COUNT_LIMIT))) begin
        count <= count + 8'd1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (tokens.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_tok) begin
      out_char  <= rd_data;
      out_end   <= idx_last;
      out_trunc <= ovf;
      out_done  <= 1'b0;
      out_count <= '0;
      out_last  <= cmd.tok_last && idx_last;
    end else if (cmd.emit_special) begin
      out_char  <= held_char;
      out_end   <= 1'b1;
      out_trunc <= 1'b0;
      out_done  <= 1'b0;
      out_count <= '0;
      out_last  <= 1'b1;
    end else if (cmd.emit_summary) begin
      out_char  <= '0;
      out_end   <= 1'b0;
      out_trunc <= 1'b0;
      out_done  <= 1'b1;
      out_count <= count;
      out_last  <= 1'b1;
    end
  end

  assign tokens.valid            = out_valid;
  assign tokens.out_char         = out_char;
  assign tokens.token_end        = out_end;
  assign tokens.token_truncated  = out_trunc;
  assign tokens.line_done        = out_done;
  assign tokens.line_token_count = out_count;
  assign tokens.last_of_run      = out_last;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(TOKEN_BUFFER_DEPTH))
    else $error("token fill beyond buffer depth");
  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    ovf |-> fill_full)
    else $error("overflow flag set with room left in buffer");
  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_tok |-> (idx_ext < fill))
    else $error("replay reads past buffered token");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 8'(COUNT_LIMIT))
    else $error("token count above limit");
  a_line_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.line_clear |=> (count == '0) && (fill == '0) && !quote_open)
    else $error("line state not cleared after summary");
`endif

endmodule

FILE: rtl/slt_controller.sv
// Tokenizer controller: accepts characters, sequences replay and summary transfers.
module slt_controller (
  input  logic                 clk,
  input  logic                 rst,
  input  slt_pkg::slt_status_t st,
  output slt_pkg::slt_cmd_t    cmd
);
  import slt_pkg::*;

  slt_state_t state, state_next;
  slt_after_t after, after_next;
  logic       accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      after <= AFTER_NONE;
    end else begin
      state <= state_next;
      after <= after_next;
    end
  end

  assign accept = st.in_valid && (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    after_next = after;
    case (state)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        cmd.capture  = accept;
        if (accept) begin
          if (st.in_op == OP_EOL) begin
            if (!st.quote_open && !st.fill_zero) begin
              cmd.rd_start = 1'b1;
              after_next   = AFTER_SUMMARY;
              state_next   = S_REPLAY;
            end else begin
              state_next = S_SUMMARY;
            end
          end else if (st.is_quote) begin
            if (!st.quote_open) begin
              cmd.quote_set = 1'b1;
              cmd.clear_tok = 1'b1;
            end else begin
              cmd.quote_clr = 1'b1;
              if (!st.fill_zero) begin
                cmd.rd_start = 1'b1;
                after_next   = AFTER_NONE;
                state_next   = S_REPLAY;
              end
            end
          end else if (!st.quote_open && (st.is_space || st.is_special)) begin
            if (!st.fill_zero) begin
              cmd.rd_start = 1'b1;
              after_next   = st.is_special ? AFTER_SPECIAL : AFTER_NONE;
              state_next   = S_REPLAY;
            end else if (st.is_special) begin
              state_next = S_SPECIAL;
            end
          end else begin
            cmd.append = 1'b1;
          end
        end
      end
      S_REPLAY: begin
        if (st.out_free) begin
          cmd.emit_tok = 1'b1;
          cmd.tok_last = (after == AFTER_NONE);
          if (st.idx_last) begin
            cmd.clear_tok = 1'b1;
            cmd.bump      = 1'b1;
            case (after)
              AFTER_SPECIAL: state_next = S_SPECIAL;
              AFTER_SUMMARY: state_next = S_SUMMARY;
              default:       state_next = S_IDLE;
            endcase
          end
        end
      end
      S_SPECIAL: begin
        if (st.out_free) begin
          cmd.emit_special = 1'b1;
          cmd.bump         = 1'b1;
          state_next       = S_IDLE;
        end
      end
      S_SUMMARY: begin
        if (st.out_free) begin
          cmd.emit_summary = 1'b1;
          cmd.line_clear   = 1'b1;
          state_next       = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_emit_needs_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_tok || cmd.emit_special || cmd.emit_summary) |-> st.out_free)
    else $error("result loaded while output register is occupied");
  a_replay_has_data: assert property (@(posedge clk) disable iff (rst)
    (state == S_REPLAY) |-> !st.fill_zero)
    else $error("replay with empty token buffer");
  a_eol_leads_summary: assert property (@(posedge clk) disable iff (rst)
    (accept && (st.in_op == OP_EOL)) |=> ((state == S_SUMMARY) ||
      ((state == S_REPLAY) && (after == AFTER_SUMMARY))))
    else $error("end of line not followed by summary");
`endif

endmodule

FILE: rtl/shell_line_tokenizer.sv
// Top level of the shell command line tokenizer.
//
// Usage:
//   chars  : one transfer per line byte (op = 0, in_char) and a final transfer
//            with op = 1 marking end of line.
//   tokens : one transfer per emitted token character, plus one line_done
//            summary per line carrying the saturating token count.
//            last_of_run marks the final result caused by an input transfer.
// Timing:
//   An ordinary byte is absorbed into the token buffer. A delimiter, closing
//   quote or end of line with buffered bytes holds chars.ready low while
//   they are replayed and while an operator token or the summary follows,
//   stretched by any receiver stall. Replay runs one byte per cycle unless
//   the receiver stalls, set by the single read port of the token buffer;
//   its first byte goes via the read register to the output register.
// Reset (rst, synchronous): clears quote state, fill, overflow and count; the
//   buffer itself needs no clearing pass since only filled entries are read.
// Stalls: a result waits in the output register while tokens.ready is low;
//   replay pauses and resumes without loss.
module shell_line_tokenizer #(
  parameter int TOKEN_BUFFER_DEPTH = 32,
  parameter int COUNT_LIMIT        = 255
) (
  input  logic        clk,
  input  logic        rst,
  slt_char_if.sink    chars,
  slt_token_if.source tokens
);
  import slt_pkg::*;

  // command and status between the control FSM and the datapath
  slt_cmd_t    cmd;
  slt_status_t st;

  slt_controller u_ctrl (
    .clk (clk),
    .rst (rst),
    .st  (st),
    .cmd (cmd)
  );

  slt_datapath #(
    .TOKEN_BUFFER_DEPTH (TOKEN_BUFFER_DEPTH),
    .COUNT_LIMIT        (COUNT_LIMIT)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .st     (st),
    .chars  (chars),
    .tokens (tokens)
  );

endmodule

FILE: verif/tb_shell_line_tokenizer.sv
// Self-checking testbench for the shell line tokenizer: stimulus, prediction and checking.
module tb_shell_line_tokenizer;
  timeunit 1ns;
  timeprecision 1ps;

  import slt_pkg::*;

  // Same sizes as the DUT instance below; the predictor works at these widths.
  localparam int TOK_DEPTH   = 32;
  localparam int COUNT_LIMIT = 255;

  // Cycles to wait after the last expected result before closing the run.
  localparam int TAIL_CYCLES = 40;
  // Bound on the final drain, in cycles.
  localparam int DRAIN_LIMIT = 50000;
  // Long receiver hold-off used to back the block up into its input.
  localparam int HOLD_OFF_CYCLES = 300;

  // One character-channel transfer.
  typedef struct packed {
    logic       op;
    logic [7:0] ch;
  } line_item_t;

  // One token-channel transfer.
  typedef struct packed {
    logic [7:0] ch;
    logic       tend;
    logic       trunc;
    logic       done;
    logic [7:0] cnt;
    logic       last;
  } token_res_t;

  logic clk = 1'b0;
  logic rst;

  slt_char_if  chars_if ();
  slt_token_if tokens_if ();

  shell_line_tokenizer #(
    .TOKEN_BUFFER_DEPTH(TOK_DEPTH),
    .COUNT_LIMIT       (COUNT_LIMIT)
  ) u_top (
    .clk   (clk),
    .rst   (rst),
    .chars (chars_if),
    .tokens(tokens_if)
  );

  // 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shared testbench state
  // ---------------------------------------------------------------------------
  line_item_t pending_q[$];    // line bytes waiting to be offered
  token_res_t expected_q[$];   // predicted token-channel transfers, oldest first
  token_res_t burst_q[$];      // results caused by the item being predicted

  int  src_idle_pct   = 0;     // chance per cycle that the sender holds back
  int  sink_stall_pct = 0;     // chance per cycle that the receiver stalls
  int  sink_hold_left = 0;     // forced receiver hold-off, counted down below
  bit  in_taken;               // char transfer seen at the last rising edge

  int  items_queued;
  int  items_sent;
  int  lines_sent;
  int  results_seen;
  int  lines_checked;
  int  trunc_tokens;
  int  saturated_lines;
  int  mismatch_count;

  // Tokenizer state mirrored by the predictor.
  logic       in_quote;
  logic [7:0] tok_buf [TOK_DEPTH];
  int         tok_fill;
  logic       tok_overflow;
  logic [7:0] line_tokens;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // The one-character operator tokens; outside quotes they also end a word.
  function automatic logic is_operator(logic [7:0] c);
    case (c)
      CH_LPAREN, CH_RPAREN, CH_LESS, CH_GREATER, CH_SEMI, CH_PIPE: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // Token count sticks at the limit; tokens keep coming out regardless.
  function automatic void bump_line_count();
    if (line_tokens < 8'(COUNT_LIMIT))
      line_tokens++;
  endfunction

  // Replays the buffered word (if any) and empties the buffer.
  // A word that overflowed carries the truncated flag on every character.
  function automatic void emit_word();
    token_res_t r;
    for (int i = 0; i < tok_fill; i++) begin
      r       = '0;
      r.ch    = tok_buf[i];
      r.tend  = (i == tok_fill - 1);
      r.trunc = tok_overflow;
      burst_q.push_back(r);
    end
    if (tok_fill > 0)
      bump_line_count();
    tok_fill     = 0;
    tok_overflow = 1'b0;
  endfunction

  // Works out every result one accepted char transfer causes.
  function automatic void predict_tokens(logic op, logic [7:0] c);
    token_res_t r;
    burst_q.delete();
    if (op == OP_EOL) begin
      // An open quote at end of line drops its text; summary always follows.
      if (!in_quote)
        emit_word();
      r      = '0;
      r.done = 1'b1;
      r.cnt  = line_tokens;
      burst_q.push_back(r);
      in_quote     = 1'b0;
      tok_fill     = 0;
      tok_overflow = 1'b0;
      line_tokens  = '0;
    end else if (c == CH_QUOTE) begin
      if (!in_quote) begin
        // opening a quote throws away unquoted bytes gathered so far
        in_quote     = 1'b1;
        tok_fill     = 0;
        tok_overflow = 1'b0;
      end else begin
        in_quote = 1'b0;
        emit_word();
      end
    end else if (!in_quote && (c == CH_SPACE || is_operator(c))) begin
      emit_word();
      if (is_operator(c)) begin
        r      = '0;
        r.ch   = c;
        r.tend = 1'b1;
        burst_q.push_back(r);
        bump_line_count();
      end
    end else if (tok_fill < TOK_DEPTH) begin
      tok_buf[tok_fill] = c;
      tok_fill++;
    end else begin
      tok_overflow = 1'b1;
    end
    if (burst_q.size() > 0)
      burst_q[burst_q.size() - 1].last = 1'b1;
    foreach (burst_q[i])
      expected_q.push_back(burst_q[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  task automatic compare_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s: got 0x%0h, want 0x%0h",
                                results_seen, name, got, want));
  endtask

  task automatic check_token(token_res_t got);
    token_res_t want;
    results_seen++;
    if (expected_q.size() == 0) begin
      report_mismatch($sformatf("result %0d arrived with nothing pending", results_seen));
      return;
    end
    want = expected_q.pop_front();
    compare_field("out_char",         got.ch,           want.ch);
    compare_field("token_end",        8'(got.tend),     8'(want.tend));
    compare_field("token_truncated",  8'(got.trunc),    8'(want.trunc));
    compare_field("line_done",        8'(got.done),     8'(want.done));
    compare_field("line_token_count", got.cnt,          want.cnt);
    compare_field("last_of_run",      8'(got.last),     8'(want.last));
    if (want.done) begin
      lines_checked++;
      if (want.cnt == 8'(COUNT_LIMIT))
        saturated_lines++;
    end
    if (want.tend && want.trunc)
      trunc_tokens++;
  endtask

  // Monitor: everything is sampled at the rising edge, where the driver's
  // falling-edge updates have long settled and the DUT's new values are not
  // yet visible. Prediction runs before the output check, and results are
  // registered after their item, so ordering is never an issue.
  always @(posedge clk) begin
    in_taken = 1'b0;
    if (!rst) begin
      if (chars_if.valid && chars_if.ready) begin
        in_taken = 1'b1;
        items_sent++;
        predict_tokens(chars_if.op, chars_if.in_char);
      end
      if (tokens_if.valid && tokens_if.ready)
        check_token('{ch:    tokens_if.out_char,
                      tend:  tokens_if.token_end,
                      trunc: tokens_if.token_truncated,
                      done:  tokens_if.line_done,
                      cnt:   tokens_if.line_token_count,
                      last:  tokens_if.last_of_run});
    end
  end

  // ---------------------------------------------------------------------------
  // Driver and receiver, both on the falling edge
  // ---------------------------------------------------------------------------

  // Sender: a valid item stays up until its transfer; a new one (or a gap)
  // is chosen only after that. Each signal gets one assignment per edge.
  always @(negedge clk) begin
    line_item_t nxt;
    if (rst) begin
      chars_if.valid <= 1'b0;
    end else if (!chars_if.valid || in_taken) begin
      if (pending_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        nxt = pending_q.pop_front();
        chars_if.valid   <= 1'b1;
        chars_if.op      <= nxt.op;
        chars_if.in_char <= nxt.ch;
      end else begin
        chars_if.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, or a forced hold-off counted down here.
  always @(negedge clk) begin
    if (rst) begin
      tokens_if.ready <= 1'b0;
    end else if (sink_hold_left > 0) begin
      tokens_if.ready <= 1'b0;
      sink_hold_left--;
    end else begin
      tokens_if.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------------

  task automatic push_char(logic [7:0] c);
    pending_q.push_back('{op: OP_CHAR, ch: c});
    items_queued++;
  endtask

  task automatic push_eol();
    // in_char is a don't-care on end of line; keep it random anyway
    pending_q.push_back('{op: OP_EOL, ch: 8'($urandom_range(255))});
    items_queued++;
    lines_sent++;
  endtask

  // A byte that lands in the buffer even outside quotes.
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do
      b = 8'($urandom_range(255));
    while (b == CH_QUOTE || b == CH_SPACE || is_operator(b));
    return b;
  endfunction

  function automatic logic [7:0] operator_byte();
    case ($urandom_range(5))
      0: return CH_LPAREN;
      1: return CH_RPAREN;
      2: return CH_LESS;
      3: return CH_GREATER;
      4: return CH_SEMI;
      default: return CH_PIPE;
    endcase
  endfunction

  // Mostly short words; now and then one long enough to overflow the buffer.
  function automatic int word_len();
    if ($urandom_range(9) == 0)
      return $urandom_range(TOK_DEPTH - 4, TOK_DEPTH + 8);
    return $urandom_range(1, 6);
  endfunction

  // One command line. Most lines are well formed (words, quoted strings,
  // operators, assorted separators); some are raw byte noise, and some end
  // with a quote left open.
  task automatic queue_random_line();
    int n_parts;
    int len;
    logic [7:0] b;
    if ($urandom_range(7) == 0) begin
      len = $urandom_range(12);
      repeat (len) push_char(8'($urandom_range(255)));
      push_eol();
      return;
    end
    n_parts = $urandom_range(6);
    for (int p = 0; p < n_parts; p++) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: begin
          len = word_len();
          repeat (len) push_char(plain_byte());
        end
        6, 7: begin
          // quoted text may hold spaces and operators; empty quotes too
          len = ($urandom_range(3) == 0) ? 0 : word_len();
          push_char(CH_QUOTE);
          repeat (len) begin
            do
              b = 8'($urandom_range(255));
            while (b == CH_QUOTE);
            push_char(b);
          end
          push_char(CH_QUOTE);
        end
        default: push_char(operator_byte());
      endcase
      case ($urandom_range(5))
        0, 1, 2: push_char(CH_SPACE);
        3:       push_char(operator_byte());
        4:       ;
        default: repeat ($urandom_range(2, 4)) push_char(CH_SPACE);
      endcase
    end
    if ($urandom_range(7) == 0) begin
      push_char(CH_QUOTE);
      repeat ($urandom_range(3)) push_char(plain_byte());
    end
    push_eol();
  endtask

  // Waits until every queued byte has gone through the handshake.
  task automatic wait_sent();
    @(posedge clk);
    while (pending_q.size() != 0 || chars_if.valid)
      @(posedge clk);
  endtask

  // One randomized phase with the given idling mix.
  task automatic run_phase(int src_pct, int sink_pct, int budget);
    int target;
    @(posedge clk);
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    target         = items_queued + budget;
    while (items_queued < target)
      queue_random_line();
    wait_sent();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    int drain_cycles;

    // Known values on every DUT input from time zero.
    rst              = 1'b1;
    chars_if.valid   = 1'b0;
    chars_if.op      = OP_CHAR;
    chars_if.in_char = '0;
    tokens_if.ready  = 1'b0;

    in_quote     = 1'b0;
    tok_fill     = 0;
    tok_overflow = 1'b0;
    line_tokens  = '0;

    repeat (12) @(negedge clk);
    rst = 1'b0;

    // Directed lines, no idling.
    @(posedge clk);
    // empty line: summary only, count zero
    push_eol();
    // zero byte and 0xFF as ordinary characters, space, every operator;
    // an operator right after a word ends that word first
    push_char(8'h00);
    push_char(8'hFF);
    push_char(CH_SPACE);
    push_char(CH_LPAREN);
    push_char("a");
    push_char(CH_RPAREN);
    push_char(CH_LESS);
    push_char(CH_GREATER);
    push_char(CH_SEMI);
    push_char(CH_PIPE);
    push_eol();
    // quoted text keeps its space and operator; "y" is discarded by the
    // quote that follows it, and the empty quote emits nothing
    push_char(CH_QUOTE);
    push_char("x");
    push_char(CH_SPACE);
    push_char(CH_PIPE);
    push_char(CH_QUOTE);
    push_char("y");
    push_char(CH_QUOTE);
    push_char(CH_QUOTE);
    push_eol();
    // quote still open at end of line: its text is dropped, summary stays
    push_char("z");
    push_char(CH_QUOTE);
    push_char("q");
    push_eol();
    wait_sent();

    // Random traffic under each idling mix; first phase has no gaps at all.
    run_phase(0,  0,  20);
    run_phase(69, 0,  20);
    run_phase(0,  69, 20);
    run_phase(9,  9,  20);

    // Count limit: one line with more operator tokens than the counter holds.
    @(posedge clk);
    repeat (COUNT_LIMIT + 2) push_char(operator_byte());
    repeat (3) push_char(plain_byte());
    push_eol();
    wait_sent();

    // Back-pressure: receiver holds off for a long stretch while the sender
    // keeps offering, so the output stalls and the block refuses input.
    @(posedge clk);
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    sink_hold_left = HOLD_OFF_CYCLES;
    repeat (3) queue_random_line();
    wait_sent();

    // Drain whatever is still owed, then let the block idle for TAIL_CYCLES
    // so any stray result shows up as unexpected.
    drain_cycles = 0;
    while (expected_q.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
      @(negedge clk);
      drain_cycles++;
    end
    repeat (TAIL_CYCLES) @(negedge clk);
    if (expected_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_q.size()));

    $display("Sent %0d characters/end-of-line transfers over %0d lines; checked %0d results.",
             items_sent, lines_sent, results_seen);
    $display("Covered %0d truncated tokens, %0d lines at the count limit, a %0d-cycle hold-off.",
             trunc_tokens, saturated_lines, HOLD_OFF_CYCLES);
    if (mismatch_count == 0)
      $display("** shell_line_tokenizer: PASSED **");
    else
      $display("** shell_line_tokenizer: FAILED **");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of this stimulus.
  initial begin
    #1_000_000;
    $display("Timeout with %0d results outstanding", expected_q.size());
    $display("** shell_line_tokenizer: FAILED **");
    $finish;
  end

endmodule
